@@ hdl/ppm_pkg.sv @@
// shared constants, command and status types for the point-to-point motion profile unit
package ppm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;

    localparam logic [32:0] SNAP_EPS      = 33'(((64'(2) << FRAC_BITS) + 64'(500)) / 64'(1000));
    localparam logic [31:0] MAX_SPEED_RST = 32'(64'(1) << FRAC_BITS);

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_CW     = $clog2(DIV_STEPS + 1);
    localparam int SQRT_CW    = $clog2(SQRT_STEPS + 1);

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TGT_X = 3'd0;
    localparam t_cfg_idx CFG_TGT_Y = 3'd1;
    localparam t_cfg_idx CFG_TGT_Z = 3'd2;
    localparam t_cfg_idx CFG_MAX   = 3'd3;
    localparam t_cfg_idx CFG_ACCEL = 3'd4;
    localparam t_cfg_idx CFG_DECEL = 3'd5;

    typedef logic [1:0] t_req;
    localparam t_req REQ_KEEP  = 2'd0;
    localparam t_req REQ_START = 2'd1;
    localparam t_req REQ_STOP  = 2'd2;
    localparam t_req REQ_SPARE = 2'd3;

    typedef logic [4:0] t_op;
    localparam t_op OP_NONE  = 5'd0;
    localparam t_op OP_LOAD  = 5'd1;
    localparam t_op OP_DIFF  = 5'd2;
    localparam t_op OP_SQ    = 5'd3;
    localparam t_op OP_SQRT  = 5'd4;
    localparam t_op OP_LEN   = 5'd5;
    localparam t_op OP_SNAP  = 5'd6;
    localparam t_op OP_MM    = 5'd7;
    localparam t_op OP_DIVDD = 5'd8;
    localparam t_op OP_ML    = 5'd9;
    localparam t_op OP_DIVAL = 5'd10;
    localparam t_op OP_AL    = 5'd11;
    localparam t_op OP_ACC   = 5'd12;
    localparam t_op OP_SPD   = 5'd13;
    localparam t_op OP_TRV   = 5'd14;
    localparam t_op OP_TRVS  = 5'd15;
    localparam t_op OP_QM    = 5'd16;
    localparam t_op OP_QD    = 5'd17;
    localparam t_op OP_QS    = 5'd18;
    localparam t_op OP_OUT   = 5'd19;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic running;
        logic snap;
        logic dzero;
        logic brake;
        logic sqrt_done;
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

@@ hdl/ppm_div.sv @@
// restoring divider, one quotient bit per cycle
module ppm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [63:0] o_quo,
    output logic        o_done
);
    import ppm_pkg::*;

    logic [63:0]       r_rem;
    logic [63:0]       r_quo;
    logic [63:0]       r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [64:0]       w_sh;
    logic [64:0]       w_sub;
    logic              w_ge;

    assign w_sh  = {r_rem, r_quo[63]};
    assign w_sub = w_sh - {1'b0, r_den};
    assign w_ge  = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[63:0] : w_sh[63:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

@@ hdl/ppm_sqrt.sv @@
// integer square root, one root bit per cycle
module ppm_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic [31:0] o_root,
    output logic        o_done
);
    import ppm_pkg::*;

    logic [63:0]        r_val;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [SQRT_CW-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [33:0]        w_rem2;
    logic [33:0]        w_trial;
    logic               w_ge;

    assign w_rem2  = {r_rem[31:0], r_val[63:62]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = w_rem2 >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SQRT_CW'(SQRT_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SQRT_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[61:0], 2'b00};
            r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[30:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

@@ hdl/ppm_dp.sv @@
// datapath: registers, shared multiplier, divider, square root and output beat
module ppm_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppm_pkg::t_cmd  i_cmd,
    output ppm_pkg::t_stat o_stat,
    input  logic           i_cfg_valid,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    input  logic [111:0]   i_in_data,
    input  logic [1:0]     i_in_user,
    output logic [127:0]   o_out_data,
    output logic [2:0]     o_out_user,
    output logic           o_out_valid,
    input  logic           i_out_ready
);
    import ppm_pkg::*;

    logic [31:0]  r_tgt [3];
    logic [31:0]  r_max;
    logic [31:0]  r_acc;
    logic [31:0]  r_dec;
    logic [31:0]  r_cur [3];
    logic [15:0]  r_dt;
    logic         r_running;
    logic [31:0]  r_speed;
    logic [31:0]  r_mag [3];
    logic         r_neg [3];
    logic         r_shift;
    logic [63:0]  r_prod;
    logic [63:0]  r_sum;
    logic         r_sq_pend;
    logic [32:0]  r_len;
    logic [63:0]  r_d2;
    logic [31:0]  r_allowed;
    logic [31:0]  r_travel;
    logic [31:0]  r_new [3];
    logic         r_moved;
    logic         r_reached;
    logic [127:0] r_odata;
    logic [2:0]   r_ouser;
    logic         r_ovalid;

    logic [32:0]  w_d [3];
    logic [32:0]  w_dn [3];
    logic [31:0]  w_mag [3];
    logic         w_big;
    logic [31:0]  w_ma;
    logic [31:0]  w_mb;
    logic [31:0]  w_sq;
    logic         w_div_start;
    logic [63:0]  w_num;
    logic [63:0]  w_den;
    logic [63:0]  w_quo;
    logic         w_div_done;
    logic [31:0]  w_root;
    logic         w_sqrt_done;
    logic         w_run_next;
    logic [31:0]  w_inc;
    logic [32:0]  w_ns33;
    logic [31:0]  w_ns;
    logic [31:0]  w_tr;
    logic [31:0]  w_q;

    always_comb begin
        w_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_d[i]   = {r_tgt[i][31], r_tgt[i]} - {r_cur[i][31], r_cur[i]};
            w_dn[i]  = 33'd0 - w_d[i];
            w_mag[i] = w_d[i][32] ? w_dn[i][31:0] : w_d[i][31:0];
            w_big    = w_big | w_mag[i][31];
        end
    end

    assign w_sq = r_shift ? {1'b0, r_mag[i_cmd.axis][31:1]} : r_mag[i_cmd.axis];

    always_comb begin
        unique case (i_cmd.op)
            OP_SQ: begin
                w_ma = w_sq;
                w_mb = w_sq;
            end
            OP_MM: begin
                w_ma = r_max;
                w_mb = r_max;
            end
            OP_ML: begin
                w_ma = r_max;
                w_mb = r_len[32] ? r_len[32:1] : r_len[31:0];
            end
            OP_ACC: begin
                w_ma = r_acc;
                w_mb = {16'd0, r_dt};
            end
            OP_TRV: begin
                w_ma = r_speed;
                w_mb = {16'd0, r_dt};
            end
            OP_QM: begin
                w_ma = r_mag[i_cmd.axis];
                w_mb = r_travel;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_num       = r_prod;
        w_den       = {32'd0, r_dec};
        unique case (i_cmd.op)
            OP_DIVDD: w_div_start = 1'b1;
            OP_DIVAL: begin
                w_div_start = 1'b1;
                w_den       = r_d2;
            end
            OP_QD: begin
                w_div_start = 1'b1;
                w_den       = {31'd0, r_len};
            end
            default: w_div_start = 1'b0;
        endcase
    end

    ppm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    ppm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_val   (r_sum),
        .o_root  (w_root),
        .o_done  (w_sqrt_done)
    );

    always_comb begin
        w_run_next = r_running;
        if (i_in_user == REQ_START) begin
            w_run_next = 1'b1;
        end else if (i_in_user == REQ_STOP) begin
            w_run_next = 1'b0;
        end
    end

    assign w_inc  = r_prod[DT_BITS +: 32];
    assign w_ns33 = {1'b0, r_speed} + {1'b0, w_inc};
    assign w_ns   = (r_acc == '0) ? r_max : (w_ns33[32] ? '1 : w_ns33[31:0]);
    assign w_tr   = r_prod[DT_BITS +: 32];
    assign w_q    = w_quo[31:0];

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt[0]  <= '0;
            r_tgt[1]  <= '0;
            r_tgt[2]  <= '0;
            r_max     <= MAX_SPEED_RST;
            r_acc     <= '0;
            r_dec     <= '0;
            r_running <= 1'b0;
            r_speed   <= '0;
            r_ovalid  <= 1'b0;
            r_sq_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TGT_X: r_tgt[0] <= i_cfg_data;
                    CFG_TGT_Y: r_tgt[1] <= i_cfg_data;
                    CFG_TGT_Z: r_tgt[2] <= i_cfg_data;
                    CFG_MAX:   r_max    <= i_cfg_data;
                    CFG_ACCEL: r_acc    <= i_cfg_data;
                    CFG_DECEL: r_dec    <= i_cfg_data;
                    default:   r_max    <= r_max;
                endcase
            end
            r_sq_pend <= (i_cmd.op == OP_SQ);
            if (i_cmd.op == OP_LOAD) begin
                r_running <= w_run_next;
            end else if (i_cmd.op == OP_SNAP) begin
                r_running <= 1'b0;
            end
            if (i_cmd.op == OP_SPD) begin
                r_speed <= (w_ns < r_allowed) ? w_ns : r_allowed;
            end
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (r_sq_pend) begin
            r_sum <= r_sum + r_prod;
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_cur[0]  <= i_in_data[31:0];
                r_cur[1]  <= i_in_data[63:32];
                r_cur[2]  <= i_in_data[95:64];
                r_dt      <= i_in_data[111:96];
                r_new[0]  <= i_in_data[31:0];
                r_new[1]  <= i_in_data[63:32];
                r_new[2]  <= i_in_data[95:64];
                r_moved   <= w_run_next;
                r_reached <= 1'b0;
            end
            OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= w_mag[i];
                    r_neg[i] <= w_d[i][32];
                end
                r_shift <= w_big;
                r_sum   <= '0;
            end
            OP_LEN: begin
                r_len     <= r_shift ? {w_root, 1'b0} : {1'b0, w_root};
                r_allowed <= r_max;
            end
            OP_SNAP: begin
                r_new[0]  <= r_tgt[0];
                r_new[1]  <= r_tgt[1];
                r_new[2]  <= r_tgt[2];
                r_reached <= 1'b1;
            end
            OP_ML:   r_d2      <= r_len[32] ? {1'b0, w_quo[63:1]} : w_quo;
            OP_AL:   r_allowed <= w_q;
            OP_TRVS: r_travel  <= ({1'b0, w_tr} > r_len) ? r_len[31:0] : w_tr;
            OP_QS: begin
                r_new[i_cmd.axis] <= r_neg[i_cmd.axis] ? (r_cur[i_cmd.axis] - w_q)
                                                       : (r_cur[i_cmd.axis] + w_q);
            end
            OP_OUT: begin
                r_odata <= {r_speed, r_new[2], r_new[1], r_new[0]};
                r_ouser <= {r_running, r_reached, r_moved};
            end
            default: r_moved <= r_moved;
        endcase
    end

    assign o_stat.running   = r_running;
    assign o_stat.snap      = r_len <= SNAP_EPS;
    assign o_stat.dzero     = r_dec == '0;
    assign o_stat.brake     = (w_quo != '0) && ({31'd0, r_len} <= w_quo);
    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_busy  = r_ovalid && !i_out_ready;

    assign o_out_data  = r_odata;
    assign o_out_user  = r_ouser;
    assign o_out_valid = r_ovalid;

`ifndef SYNTHESIS
    a_snap_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SNAP) |=> (!r_running && r_reached))
        else $error("snap left the unit running");
    a_travel_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_TRVS) |=> ({1'b0, r_travel} <= r_len))
        else $error("travel beyond distance");
    a_speed_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SPD) |=> (r_speed <= $past(r_allowed)))
        else $error("speed above allowed limit");
`endif

endmodule

@@ hdl/ppm_ctrl.sv @@
// controller: sequences one tick through the datapath
module ppm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ppm_pkg::t_stat i_stat,
    output ppm_pkg::t_cmd  o_cmd
);
    import ppm_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DIFF = 5'd1;
    localparam logic [4:0] S_SQ0  = 5'd2;
    localparam logic [4:0] S_SQ1  = 5'd3;
    localparam logic [4:0] S_SQ2  = 5'd4;
    localparam logic [4:0] S_SQW  = 5'd5;
    localparam logic [4:0] S_RT   = 5'd6;
    localparam logic [4:0] S_RTW  = 5'd7;
    localparam logic [4:0] S_LEN  = 5'd8;
    localparam logic [4:0] S_CHK  = 5'd9;
    localparam logic [4:0] S_SNAP = 5'd10;
    localparam logic [4:0] S_MM   = 5'd11;
    localparam logic [4:0] S_DD   = 5'd12;
    localparam logic [4:0] S_DDW  = 5'd13;
    localparam logic [4:0] S_BRK  = 5'd14;
    localparam logic [4:0] S_ML   = 5'd15;
    localparam logic [4:0] S_DAL  = 5'd16;
    localparam logic [4:0] S_ALW  = 5'd17;
    localparam logic [4:0] S_AL   = 5'd18;
    localparam logic [4:0] S_ACC  = 5'd19;
    localparam logic [4:0] S_SPD  = 5'd20;
    localparam logic [4:0] S_TRV  = 5'd21;
    localparam logic [4:0] S_TRVS = 5'd22;
    localparam logic [4:0] S_QM   = 5'd23;
    localparam logic [4:0] S_QD   = 5'd24;
    localparam logic [4:0] S_QDW  = 5'd25;
    localparam logic [4:0] S_QS   = 5'd26;
    localparam logic [4:0] S_OUT  = 5'd27;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [1:0] r_ax;
    logic [1:0] n_ax;

    always_comb begin
        n_state    = r_state;
        n_ax       = r_ax;
        o_cmd.op   = OP_NONE;
        o_cmd.axis = r_ax;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = i_stat.running ? S_SQ0 : S_OUT;
            end
            S_SQ0: begin
                o_cmd.op   = OP_SQ;
                o_cmd.axis = 2'd0;
                n_state    = S_SQ1;
            end
            S_SQ1: begin
                o_cmd.op   = OP_SQ;
                o_cmd.axis = 2'd1;
                n_state    = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.op   = OP_SQ;
                o_cmd.axis = 2'd2;
                n_state    = S_SQW;
            end
            S_SQW: n_state = S_RT;
            S_RT: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_RTW;
            end
            S_RTW: if (i_stat.sqrt_done) begin
                n_state = S_LEN;
            end
            S_LEN: begin
                o_cmd.op = OP_LEN;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_stat.snap) begin
                    n_state = S_SNAP;
                end else if (i_stat.dzero) begin
                    n_state = S_ACC;
                end else begin
                    n_state = S_MM;
                end
            end
            S_SNAP: begin
                o_cmd.op = OP_SNAP;
                n_state  = S_OUT;
            end
            S_MM: begin
                o_cmd.op = OP_MM;
                n_state  = S_DD;
            end
            S_DD: begin
                o_cmd.op = OP_DIVDD;
                n_state  = S_DDW;
            end
            S_DDW: if (i_stat.div_done) begin
                n_state = S_BRK;
            end
            S_BRK: n_state = i_stat.brake ? S_ML : S_ACC;
            S_ML: begin
                o_cmd.op = OP_ML;
                n_state  = S_DAL;
            end
            S_DAL: begin
                o_cmd.op = OP_DIVAL;
                n_state  = S_ALW;
            end
            S_ALW: if (i_stat.div_done) begin
                n_state = S_AL;
            end
            S_AL: begin
                o_cmd.op = OP_AL;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = S_SPD;
            end
            S_SPD: begin
                o_cmd.op = OP_SPD;
                n_state  = S_TRV;
            end
            S_TRV: begin
                o_cmd.op = OP_TRV;
                n_state  = S_TRVS;
            end
            S_TRVS: begin
                o_cmd.op = OP_TRVS;
                n_ax     = 2'd0;
                n_state  = S_QM;
            end
            S_QM: begin
                o_cmd.op = OP_QM;
                n_state  = S_QD;
            end
            S_QD: begin
                o_cmd.op = OP_QD;
                n_state  = S_QDW;
            end
            S_QDW: if (i_stat.div_done) begin
                n_state = S_QS;
            end
            S_QS: begin
                o_cmd.op = OP_QS;
                if (r_ax == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_QM;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_ax    <= n_ax;
        end
    end

endmodule

@@ hdl/point_to_point_motion_profile_unit.sv @@
// top level of the point-to-point motion profile unit
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | s_axis_tvalid/tready/tdata/tuser          | in
//  result    | m_axis_tvalid/tready/tdata/tuser          | out
//  config    | i_cfg_valid/o_cfg_ready/index/data        | in
//
//  one beat in, one beat out, one tick at a time; a stopped tick skips the arithmetic,
//  an arriving one runs only the square root, a moving one also passes through the
//  shared one-bit-per-cycle divider (three axes, up to two for braking)
//  reset is synchronous active low, no clearing pass; a waiting result beat holds
//  only the next result, a new input beat is still taken; config always ready
module point_to_point_motion_profile_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // cur_x, cur_y, cur_z, time_step
    input  logic [1:0]   s_axis_tuser,  // run_request
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // new_x, new_y, new_z, speed_now
    output logic [2:0]   m_axis_tuser,  // moved, reached_end, is_running
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ppm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ppm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ppm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the point-to-point motion profile unit
module testbench;
    import ppm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_cfg_idx CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [31:0] x, y, z;
        logic [15:0] dt;
        t_req        req;
    } t_tick;

    typedef struct packed {
        logic [31:0] x, y, z, spd;
        logic        moved, arrived, run;
    } t_pose;

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid, m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         i_cfg_valid, o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    point_to_point_motion_profile_unit uut (.*);

    logic [31:0] tgt [3];
    logic [31:0] vmax, acc, dec;
    logic        moving;
    logic [31:0] speed;
    t_pose       pose_q [$];
    int          errors;
    int          hold_cycles;
    bit          rx_random;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_pose advance(t_tick t);
        t_pose p;
        logic signed [33:0] dv [3];
        logic [63:0] mg [3];
        logic [63:0] sum, len, dd, l2, d2, allowed, ns, trav, q;
        logic [31:0] cx [3];
        int sh;
        cx[0] = t.x; cx[1] = t.y; cx[2] = t.z;
        if (t.req == REQ_START) moving = 1;
        else if (t.req == REQ_STOP) moving = 0;
        p = '0;
        p.x = t.x; p.y = t.y; p.z = t.z;
        if (moving) begin
            p.moved = 1;
            sh = 0;
            for (int i = 0; i < 3; i++) begin
                dv[i] = 34'(signed'(tgt[i])) - 34'(signed'(cx[i]));
                mg[i] = dv[i] < 0 ? 64'(-dv[i]) : 64'(dv[i]);
                if (mg[i] >= 64'h8000_0000) sh = 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum += (mg[i] >> sh) * (mg[i] >> sh);
            len = root64(sum) << sh;
            if (len <= 64'(SNAP_EPS)) begin
                moving = 0;
                p.x = tgt[0]; p.y = tgt[1]; p.z = tgt[2];
                p.arrived = 1;
            end else begin
                allowed = vmax;
                if (dec != 0) begin
                    dd = (64'(vmax) * 64'(vmax)) / 64'(dec);
                    if (dd != 0 && len <= dd) begin
                        l2 = len; d2 = dd;
                        while (l2 > 64'hFFFF_FFFF) begin
                            l2 = l2 >> 1; d2 = d2 >> 1;
                        end
                        allowed = (64'(vmax) * l2) / d2;
                    end
                end
                if (acc != 0) begin
                    ns = 64'(speed) + ((64'(t.dt) * 64'(acc)) >> DT_BITS);
                    if (ns > 64'hFFFF_FFFF) ns = 64'hFFFF_FFFF;
                end else begin
                    ns = vmax;
                end
                speed = 32'(ns < allowed ? ns : allowed);
                trav = (64'(speed) * 64'(t.dt)) >> DT_BITS;
                if (trav > len) trav = len;
                for (int i = 0; i < 3; i++) begin
                    q = (mg[i] * trav) / len;
                    cx[i] = dv[i] < 0 ? cx[i] - 32'(q) : cx[i] + 32'(q);
                end
                p.x = cx[0]; p.y = cx[1]; p.z = cx[2];
            end
        end
        p.run = moving;
        p.spd = speed;
        return p;
    endfunction

    task automatic send_tick(t_tick t);
        int idle;
        idle = $urandom_range(9);
        @(negedge i_clk);
        if (idle > 0) begin
            s_axis_tvalid <= 0;
            repeat (idle) @(negedge i_clk);
        end
        s_axis_tdata  <= {t.dt, t.z, t.y, t.x};
        s_axis_tuser  <= t.req;
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pose_q.push_back(advance(t));
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (450) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TGT_X: tgt[0] = val;
            CFG_TGT_Y: tgt[1] = val;
            CFG_TGT_Z: tgt[2] = val;
            CFG_MAX:   vmax = val;
            CFG_ACCEL: acc = val;
            CFG_DECEL: dec = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic t_tick near_tick(int spread);
        t_tick t;
        t.x = tgt[0] + 32'($urandom_range(2 * spread) - spread);
        t.y = tgt[1] + 32'($urandom_range(2 * spread) - spread);
        t.z = tgt[2] + 32'($urandom_range(2 * spread) - spread);
        t.dt = 16'($urandom);
        t.req = ($urandom_range(9) == 0) ? t_req'($urandom_range(3)) : REQ_KEEP;
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pose_q.size() == 0) begin
                $display("%0t unexpected beat %h %b", $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                e = pose_q.pop_front();
                if (m_axis_tdata !== {e.spd, e.z, e.y, e.x} ||
                    m_axis_tuser !== {e.run, e.arrived, e.moved}) begin
                    $display("%0t mismatch exp %h %b got %h %b", $time,
                             {e.spd, e.z, e.y, e.x}, {e.run, e.arrived, e.moved},
                             m_axis_tdata, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 0;
        end else if (rx_random) begin
            m_axis_tready <= ($urandom_range(9) < 6);
        end else begin
            m_axis_tready <= 1;
        end
    end

    task automatic test_directed();
        t_tick t;
        write_reg(CFG_TGT_X, 32'h7FFF_FFFF);
        write_reg(CFG_TGT_Y, 32'h8000_0000);
        write_reg(CFG_TGT_Z, 32'h0001_0000);
        write_reg(CFG_MAX, 32'hFFFF_FFFF);
        write_reg(CFG_ACCEL, 0);
        write_reg(CFG_DECEL, 0);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        send_tick('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, REQ_KEEP});
        send_tick('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, REQ_START});
        send_tick('{0, 0, 0, 16'h0000, REQ_KEEP});
        send_tick('{0, 0, 0, 16'h0001, REQ_SPARE});
        send_tick('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16'h8000, REQ_KEEP});
        send_tick('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16'h8000, REQ_START});
        send_tick('{32'h7FFF_FF80, 32'h8000_0000, 32'h0001_0000, 16'h8000, REQ_START});
        send_tick('{32'h7FFF_FF00, 32'h8000_0040, 32'h0000_FF00, 16'h8000, REQ_START});
        send_tick('{5, 6, 7, 16'h8000, REQ_STOP});
        send_tick('{5, 6, 7, 16'h8000, REQ_SPARE});
        drain();
        write_reg(CFG_TGT_X, 0);
        write_reg(CFG_TGT_Y, 0);
        write_reg(CFG_TGT_Z, 0);
        write_reg(CFG_MAX, 32'h0001_0000);
        write_reg(CFG_ACCEL, 32'h0000_8000);
        write_reg(CFG_DECEL, 32'h0000_4000);
        send_tick('{32'h0004_0000, 32'hFFFD_0000, 32'h0002_0000, 16'h4000, REQ_START});
        for (int i = 0; i < 6; i++) begin
            t = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 16'hFFFF, REQ_KEEP};
            send_tick(t);
        end
        drain();
        write_reg(CFG_ACCEL, 32'hFFFF_FFFF);
        write_reg(CFG_DECEL, 32'hFFFF_FFFF);
        write_reg(CFG_MAX, 0);
        send_tick('{32'h0001_0000, 0, 0, 16'hFFFF, REQ_START});
        send_tick('{32'h0000_0040, 0, 0, 16'hFFFF, REQ_START});
        drain();
    endtask

    task automatic test_random(int n);
        t_tick t;
        logic [31:0] v;
        rx_random = 1;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                drain();
                for (int r = 0; r < 6; r++) begin
                    case ($urandom_range(3))
                        0: v = 0;
                        1: v = 32'hFFFF_FFFF;
                        2: v = $urandom_range(32'h0008_0000);
                        default: v = $urandom;
                    endcase
                    if (r == 3 && $urandom_range(1)) v = $urandom_range(32'h0010_0000);
                    write_reg(t_cfg_idx'(r), v);
                end
            end
            case ($urandom_range(9))
                0: begin
                    t.x = $urandom; t.y = $urandom; t.z = $urandom;
                    t.dt = $urandom; t.req = t_req'($urandom);
                end
                1: t = near_tick(300);
                2: t = near_tick(4000000);
                default: t = near_tick(400000);
            endcase
            if ($urandom_range(14) == 0) t.req = REQ_START;
            send_tick(t);
        end
        drain();
        rx_random = 0;
    endtask

    task automatic test_backpressure();
        t_tick t;
        write_reg(CFG_ACCEL, 0);
        write_reg(CFG_DECEL, 0);
        write_reg(CFG_MAX, 32'h0004_0000);
        hold_cycles = 3000;
        for (int i = 0; i < 20; i++) begin
            t = near_tick(100000);
            t.req = REQ_START;
            send_tick(t);
        end
        drain();
    endtask

    initial begin
        errors = 0; hold_cycles = 0; rx_random = 0;
        moving = 0; speed = 0;
        tgt[0] = 0; tgt[1] = 0; tgt[2] = 0;
        vmax = MAX_SPEED_RST; acc = 0; dec = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_backpressure();
        test_random(1210);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/ppm_pkg.sv
hdl/ppm_div.sv
hdl/ppm_sqrt.sv
hdl/ppm_dp.sv
hdl/ppm_ctrl.sv
hdl/point_to_point_motion_profile_unit.sv
tb/testbench.sv
